[hw/rtl/isocc_pkg.sv]
// shared constants and register codes for the isosurface cell classifier
package isocc_pkg;

  localparam int GRID_SIZE_DEF    = 256;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int N_CORNERS        = 8;
  localparam int STEPS_PER_STAGE  = 4;
  localparam int CFG_IDX_W        = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD,
    REG_CYCLE_LENGTH,
    REG_CUT_X_LOW,
    REG_CUT_X_HIGH,
    REG_CUT_Y_LOW,
    REG_CUT_Y_HIGH,
    REG_CUT_Z_LOW,
    REG_CUT_Z_HIGH
  } cfg_reg_t;

endpackage

[hw/rtl/isocc_rem_steps.sv]
// STEPS restoring remainder steps for one corner lane, msb of the chunk first
module isocc_rem_steps #(
  parameter int DIV_W = isocc_pkg::SAMPLE_WIDTH_DEF - 1,
  parameter int STEPS = isocc_pkg::STEPS_PER_STAGE
) (
  input  logic [DIV_W-1:0] divisor,
  input  logic [DIV_W-1:0] rem_in,
  input  logic [STEPS-1:0] bits_in,
  output logic [DIV_W-1:0] rem_out
);

  logic [DIV_W:0]   t;
  logic [DIV_W-1:0] r;

  always_comb begin
    r = rem_in;
    t = '0;
    for (int i = STEPS - 1; i >= 0; i--) begin
      t = {r, bits_in[i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[DIV_W-1:0];
    end
    rem_out = r;
  end

endmodule

[hw/rtl/isosurface_cell_classifier_core.sv]
// top level of the isosurface cell classifier: cut box, threshold or phase test, case index
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | sink      | in_valid / in_stall   | cell_x, cell_y, cell_z, corner_a..corner_h
//  out     | source    | out_valid / out_stall | out_x, out_y, out_z, case_index
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one cell beat per cycle sustained while the output is not stalled; from acceptance a beat
//  passes stage 0, the remainder stages, the wrap stage and then the output register
//  the depth is set by the remainder pipeline: four restoring steps per stage, one lane per corner
//  dropped cells leave a bubble and no beat; bubbles are squeezed out under stall
//  rst is synchronous and clears every valid bit and loads the register defaults
//  cfg_ready is always high; a stalled output holds its beat and backs up stage by stage
module isosurface_cell_classifier_core #(
  parameter int GRID_SIZE    = isocc_pkg::GRID_SIZE_DEF,
  parameter int SAMPLE_WIDTH = isocc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,

  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [isocc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((SAMPLE_WIDTH > $clog2(GRID_SIZE)) ?
                 SAMPLE_WIDTH : $clog2(GRID_SIZE))-1:0] cfg_data,

  // cell input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [$clog2(GRID_SIZE)-1:0]   cell_x,
  input  logic        [$clog2(GRID_SIZE)-1:0]   cell_y,
  input  logic        [$clog2(GRID_SIZE)-1:0]   cell_z,
  input  logic signed [SAMPLE_WIDTH-1:0]        corner_a,
  input  logic signed [SAMPLE_WIDTH-1:0]        corner_b,
  input  logic signed [SAMPLE_WIDTH-1:0]        corner_c,
  input  logic signed [SAMPLE_WIDTH-1:0]        corner_d,
  input  logic signed [SAMPLE_WIDTH-1:0]        corner_e,
  input  logic signed [SAMPLE_WIDTH-1:0]        corner_f,
  input  logic signed [SAMPLE_WIDTH-1:0]        corner_g,
  input  logic signed [SAMPLE_WIDTH-1:0]        corner_h,

  // critical cell output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [$clog2(GRID_SIZE)-1:0]          out_x,
  output logic [$clog2(GRID_SIZE)-1:0]          out_y,
  output logic [$clog2(GRID_SIZE)-1:0]          out_z,
  output logic [isocc_pkg::N_CORNERS-1:0]       case_index
);

  localparam int COORD_W = $clog2(GRID_SIZE);
  localparam int SW      = SAMPLE_WIDTH;
  localparam int DIV_W   = SW - 1;                 // cycle length width
  localparam int N       = isocc_pkg::N_CORNERS;
  localparam int STEPS   = isocc_pkg::STEPS_PER_STAGE;
  localparam int ND      = (SW + STEPS - 1) / STEPS; // remainder stages
  localparam int MPAD    = ND * STEPS;              // magnitude padded with leading zeros
  localparam int LAST    = ND + 1;                  // wrap stage index

  // 0.5 in a format with three integer bits and a sign
  localparam logic [SW-1:0] TH_RESET = SW'(1) << (SW - 5);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]      threshold;
  logic        [DIV_W-1:0]   cycle_length;
  logic        [COORD_W-1:0] cut_x_low, cut_x_high;
  logic        [COORD_W-1:0] cut_y_low, cut_y_high;
  logic        [COORD_W-1:0] cut_z_low, cut_z_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= TH_RESET;
      cycle_length <= '0;
      cut_x_low    <= '1;
      cut_x_high   <= '0;
      cut_y_low    <= '1;
      cut_y_high   <= '0;
      cut_z_low    <= '1;
      cut_z_high   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (isocc_pkg::cfg_reg_t'(cfg_index))
        isocc_pkg::REG_THRESHOLD:    threshold    <= cfg_data[SW-1:0];
        isocc_pkg::REG_CYCLE_LENGTH: cycle_length <= cfg_data[DIV_W-1:0];
        isocc_pkg::REG_CUT_X_LOW:    cut_x_low    <= cfg_data[COORD_W-1:0];
        isocc_pkg::REG_CUT_X_HIGH:   cut_x_high   <= cfg_data[COORD_W-1:0];
        isocc_pkg::REG_CUT_Y_LOW:    cut_y_low    <= cfg_data[COORD_W-1:0];
        isocc_pkg::REG_CUT_Y_HIGH:   cut_y_high   <= cfg_data[COORD_W-1:0];
        isocc_pkg::REG_CUT_Z_LOW:    cut_z_low    <= cfg_data[COORD_W-1:0];
        isocc_pkg::REG_CUT_Z_HIGH:   cut_z_high   <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline payload types
  // ---------------------------------------------------------------------------
  // front and remainder stages: magnitude travels with the partial remainder
  typedef struct packed {
    logic [COORD_W-1:0]              x;
    logic [COORD_W-1:0]              y;
    logic [COORD_W-1:0]              z;
    logic                            cut;
    logic [N-1:0]                    plain;
    logic [N-1:0]                    neg;
    logic [N-1:0][MPAD-1:0]          mag;
    logic [N-1:0][DIV_W-1:0]         rem;
  } div_t;

  // wrap stage: centred remainder per corner
  typedef struct packed {
    logic [COORD_W-1:0]              x;
    logic [COORD_W-1:0]              y;
    logic [COORD_W-1:0]              z;
    logic                            cut;
    logic [N-1:0]                    plain;
    logic [N-1:0][DIV_W:0]           r;
  } wrap_t;

  div_t  stg [0:ND];
  wrap_t wrp;
  logic  vld [0:LAST];
  logic  en  [0:LAST];
  logic  en_out;

  // ---------------------------------------------------------------------------
  // flow control: a stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------------
  always_comb begin
    en_out   = !out_valid || !out_stall;
    en[LAST] = !vld[LAST] || en_out;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  // ---------------------------------------------------------------------------
  // stage 0: cut box, plain compare, difference to threshold as sign and magnitude
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] corner [N];
  div_t                 s0_next;
  logic signed [SW:0]   diff;
  logic        [SW:0]   absd;

  always_comb begin
    corner[0] = corner_a;
    corner[1] = corner_b;
    corner[2] = corner_c;
    corner[3] = corner_d;
    corner[4] = corner_e;
    corner[5] = corner_f;
    corner[6] = corner_g;
    corner[7] = corner_h;

    s0_next     = '0;
    diff        = '0;
    absd        = '0;
    s0_next.x   = cell_x;
    s0_next.y   = cell_y;
    s0_next.z   = cell_z;
    // inclusive box; an inverted bound pair matches nothing
    s0_next.cut = (cell_x >= cut_x_low) && (cell_x <= cut_x_high) &&
                  (cell_y >= cut_y_low) && (cell_y <= cut_y_high) &&
                  (cell_z >= cut_z_low) && (cell_z <= cut_z_high);
    for (int n = 0; n < N; n++) begin
      s0_next.plain[n] = corner[n] > threshold;
      diff             = {corner[n][SW-1], corner[n]} - {threshold[SW-1], threshold};
      absd             = diff[SW] ? (~diff + 1'b1) : diff;
      s0_next.neg[n]   = diff[SW];
      s0_next.mag[n]   = MPAD'(absd[SW-1:0]);
      s0_next.rem[n]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stg[0] <= s0_next;
    end
  end

  // ---------------------------------------------------------------------------
  // remainder stages: |diff| mod cycle_length, four bits per stage, eight lanes
  // ---------------------------------------------------------------------------
  for (genvar k = 1; k <= ND; k++) begin : g_div
    logic [N-1:0][DIV_W-1:0] rem_next;
    div_t                    stg_next;

    for (genvar n = 0; n < N; n++) begin : g_lane
      isocc_rem_steps #(
        .DIV_W (DIV_W),
        .STEPS (STEPS)
      ) u_steps (
        .divisor (cycle_length),
        .rem_in  (stg[k-1].rem[n]),
        .bits_in (stg[k-1].mag[n][MPAD-1-(k-1)*STEPS -: STEPS]),
        .rem_out (rem_next[n])
      );
    end

    always_comb begin
      stg_next     = stg[k-1];
      stg_next.rem = rem_next;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        stg[k] <= stg_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // wrap stage: floor remainder from the sign, then centre into [-c/2, c/2)
  // ---------------------------------------------------------------------------
  wrap_t                wrp_next;
  logic [DIV_W-1:0]     fm;

  always_comb begin
    wrp_next       = '0;
    fm             = '0;
    wrp_next.x     = stg[ND].x;
    wrp_next.y     = stg[ND].y;
    wrp_next.z     = stg[ND].z;
    wrp_next.cut   = stg[ND].cut;
    wrp_next.plain = stg[ND].plain;
    for (int n = 0; n < N; n++) begin
      // a negative difference with a non-zero remainder folds to c - rem
      if (stg[ND].neg[n] && (stg[ND].rem[n] != '0)) begin
        fm = cycle_length - stg[ND].rem[n];
      end else begin
        fm = stg[ND].rem[n];
      end
      if ({fm, 1'b0} >= {1'b0, cycle_length}) begin
        wrp_next.r[n] = {1'b0, fm} - {1'b0, cycle_length};
      end else begin
        wrp_next.r[n] = {1'b0, fm};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[LAST] <= 1'b0;
    end else if (en[LAST]) begin
      vld[LAST] <= vld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      wrp <= wrp_next;
    end
  end

  // ---------------------------------------------------------------------------
  // decision and output register
  // ---------------------------------------------------------------------------
  logic signed [DIV_W+2:0] quad;
  logic signed [DIV_W+2:0] c_pos;
  logic signed [DIV_W+2:0] c_neg;
  logic [N-1:0]            phase_mask;
  logic                    phase_bad;
  logic [N-1:0]            mask;
  logic                    keep;

  always_comb begin
    c_pos      = {3'b000, cycle_length};
    c_neg      = -c_pos;
    quad       = '0;
    phase_mask = '0;
    phase_bad  = 1'b0;
    for (int n = 0; n < N; n++) begin
      quad          = {wrp.r[n], 2'b00};
      // beyond a quarter cycle either way spoils the whole cell
      phase_bad     = phase_bad || (quad > c_pos) || (quad < c_neg);
      phase_mask[n] = $signed(wrp.r[n]) > 0;
    end
    mask = (cycle_length == '0) ? wrp.plain : phase_mask;
    keep = !wrp.cut && !((cycle_length != '0) && phase_bad) &&
           (mask != '0) && (mask != '1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= vld[LAST] && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_x      <= wrp.x;
      out_y      <= wrp.y;
      out_z      <= wrp.z;
      case_index <= mask;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // cells with no surface crossing never leave the block
  a_case_critical: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((case_index != '0) && (case_index != '1)))
    else $error("trivial case index on output");

  // back-pressure on the input only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (vld[0] && vld[LAST] && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat survived reset");

endmodule
